// ===== rtl/core/ssort_pkg.sv =====
// Shared types and constants of the stack selection sorter.
`default_nettype none

package ssort_pkg;

    localparam int VALUE_W = 32;

    typedef enum logic [2:0] {
        S_LOAD,
        S_FETCH,
        S_SCAN,
        S_SWAP,
        S_EMIT
    } t_state;

    // Control of the shared minimum unit in the scan state.
    typedef struct packed {
        logic en;
        logic first;
    } t_min_ctl;

endpackage

`default_nettype wire

// ===== rtl/core/ssort_if.sv =====
// Stream interfaces of the stack selection sorter.
`default_nettype none

interface ssort_in_if;
    logic                               valid;
    logic                               ready;
    logic signed [ssort_pkg::VALUE_W-1:0] item_value;
    logic                               batch_end;

    modport source (output valid, output item_value, output batch_end, input ready);
    modport sink   (input valid, input item_value, input batch_end, output ready);
endinterface

interface ssort_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [ssort_pkg::VALUE_W-1:0] sorted_value;
    logic                               run_end;
    logic                               overflowed;

    modport source (output valid, output sorted_value, output run_end, output overflowed,
                    input ready);
    modport sink   (input valid, input sorted_value, input run_end, input overflowed,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/core/ssort_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ssort_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire                                    i_clk,
    input  wire                                    i_we,
    input  wire [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire [WIDTH-1:0]                        i_wdata,
    input  wire                                    i_re,
    input  wire [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/core/ssort_min_unit.sv =====
// Shared signed minimum tracker used by every selection pass.
`default_nettype none

module ssort_min_unit #(
    parameter int IDX_W = 6
) (
    input  wire                               i_clk,
    input  ssort_pkg::t_min_ctl               i_ctl,
    input  wire [ssort_pkg::VALUE_W-1:0]      i_data,
    input  wire [IDX_W-1:0]                   i_data_idx,
    output logic [ssort_pkg::VALUE_W-1:0]     o_best,
    output logic [IDX_W-1:0]                  o_best_idx
);

    logic [ssort_pkg::VALUE_W-1:0] r_best;
    logic [IDX_W-1:0]              r_best_idx;
    logic                          w_less;

    // Strictly less keeps the earliest of equal values, as the pass order requires.
    assign w_less = $signed(i_data) < $signed(r_best);

    always_ff @(posedge i_clk) begin
        if (i_ctl.en && (i_ctl.first || w_less)) begin
            r_best     <= i_data;
            r_best_idx <= i_data_idx;
        end
    end

    assign o_best     = r_best;
    assign o_best_idx = r_best_idx;

endmodule

`default_nettype wire

// ===== rtl/core/stack_selection_sort.sv =====
// Top level of the stack selection sorter: load sequencer, RAM and shared minimum unit.
//
//   channel  | modport | payload                              | role
//   ---------+---------+--------------------------------------+--------------------------
//   i_in     | sink    | item_value, batch_end                | one push per transfer
//   o_out    | source  | sorted_value, run_end, overflowed    | batch in ascending order
//
// After the batch end, each pass over the values is paced by the single RAM read
// port that the scan walks one entry a cycle, and waits for its output transfer.
// Synchronous active-low reset empties the stack and clears the drop flag.
// The input is not ready while a batch is sorted or emitted; a stalled output
// holds the sequencer in place.
`default_nettype none

module stack_selection_sort #(
    parameter int STACK_DEPTH = 64
) (
    input  wire           i_clk,
    input  wire           i_rst_n,
    ssort_in_if.sink      i_in,
    ssort_out_if.source   o_out
);

    localparam int IDXW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNTW = $clog2(STACK_DEPTH + 1);
    localparam int VW   = ssort_pkg::VALUE_W;

    ssort_pkg::t_state r_state, n_state;
    logic [CNTW-1:0]   r_count, n_count;
    logic              r_drop, n_drop;
    logic [IDXW-1:0]   r_pass, n_pass;
    logic [CNTW-1:0]   r_scan, n_scan;
    logic [IDXW-1:0]   r_data_idx, n_data_idx;
    logic              r_first, n_first;
    logic [VW-1:0]     r_pass_val, n_pass_val;
    logic [VW-1:0]     r_out_value, n_out_value;
    logic              r_out_end, n_out_end;
    logic              r_out_ovf, n_out_ovf;

    logic              w_we;
    logic [IDXW-1:0]   w_waddr;
    logic [VW-1:0]     w_wdata;
    logic              w_re;
    logic [IDXW-1:0]   w_raddr;
    logic [VW-1:0]     w_rdata;
    logic [IDXW-1:0]   w_last_idx;
    logic [CNTW-1:0]   w_count_m1;
    ssort_pkg::t_min_ctl w_min_ctl;
    logic [VW-1:0]     w_best;
    logic [IDXW-1:0]   w_best_idx;

    assign w_count_m1 = CNTW'(r_count - 1'b1);
    assign w_last_idx = w_count_m1[IDXW-1:0];

    ssort_ram #(
        .WIDTH (VW),
        .DEPTH (STACK_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    ssort_min_unit #(
        .IDX_W (IDXW)
    ) u_min (
        .i_clk      (i_clk),
        .i_ctl      (w_min_ctl),
        .i_data     (w_rdata),
        .i_data_idx (r_data_idx),
        .o_best     (w_best),
        .o_best_idx (w_best_idx)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ssort_pkg::S_LOAD;
            r_count <= '0;
            r_drop  <= 1'b0;
            r_pass  <= '0;
            r_first <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_drop  <= n_drop;
            r_pass  <= n_pass;
            r_first <= n_first;
        end
    end

    always_ff @(posedge i_clk) begin
        r_scan      <= n_scan;
        r_data_idx  <= n_data_idx;
        r_pass_val  <= n_pass_val;
        r_out_value <= n_out_value;
        r_out_end   <= n_out_end;
        r_out_ovf   <= n_out_ovf;
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_drop      = r_drop;
        n_pass      = r_pass;
        n_scan      = r_scan;
        n_data_idx  = r_data_idx;
        n_first     = r_first;
        n_pass_val  = r_pass_val;
        n_out_value = r_out_value;
        n_out_end   = r_out_end;
        n_out_ovf   = r_out_ovf;
        w_we        = 1'b0;
        w_waddr     = r_count[IDXW-1:0];
        w_wdata     = i_in.item_value;
        w_re        = 1'b0;
        w_raddr     = r_pass;
        w_min_ctl   = '0;
        i_in.ready  = 1'b0;
        o_out.valid = 1'b0;

        unique case (r_state)
            ssort_pkg::S_LOAD: begin
                i_in.ready = 1'b1;
                if (i_in.valid) begin
                    if (r_count < CNTW'(STACK_DEPTH)) begin
                        w_we    = 1'b1;
                        n_count = CNTW'(r_count + 1'b1);
                    end else begin
                        n_drop = 1'b1;
                    end
                    if (i_in.batch_end) begin
                        n_pass  = '0;
                        n_state = ssort_pkg::S_FETCH;
                    end
                end
            end
            ssort_pkg::S_FETCH: begin
                // The first word of a pass is the current head of the unsorted part.
                w_re       = 1'b1;
                w_raddr    = r_pass;
                n_data_idx = r_pass;
                n_scan     = CNTW'(CNTW'(r_pass) + 1'b1);
                n_first    = 1'b1;
                n_state    = ssort_pkg::S_SCAN;
            end
            ssort_pkg::S_SCAN: begin
                w_re            = 1'b1;
                w_raddr         = r_scan[IDXW-1:0];
                n_scan          = CNTW'(r_scan + 1'b1);
                n_data_idx      = r_scan[IDXW-1:0];
                w_min_ctl.en    = 1'b1;
                w_min_ctl.first = r_first;
                n_first         = 1'b0;
                if (r_first) begin
                    n_pass_val = w_rdata;
                end
                if (r_data_idx == w_last_idx) begin
                    n_state = ssort_pkg::S_SWAP;
                end
            end
            ssort_pkg::S_SWAP: begin
                // The head value moves into the slot the minimum leaves behind.
                w_we        = 1'b1;
                w_waddr     = w_best_idx;
                w_wdata     = r_pass_val;
                n_out_value = w_best;
                n_out_end   = (r_pass == w_last_idx);
                n_out_ovf   = r_drop;
                n_state     = ssort_pkg::S_EMIT;
            end
            ssort_pkg::S_EMIT: begin
                o_out.valid = 1'b1;
                if (o_out.ready) begin
                    if (r_out_end) begin
                        n_count = '0;
                        n_drop  = 1'b0;
                        n_state = ssort_pkg::S_LOAD;
                    end else begin
                        n_pass  = IDXW'(r_pass + 1'b1);
                        n_state = ssort_pkg::S_FETCH;
                    end
                end
            end
            default: begin
                n_state = ssort_pkg::S_LOAD;
            end
        endcase
    end

    assign o_out.sorted_value = r_out_value;
    assign o_out.run_end      = r_out_end;
    assign o_out.overflowed   = r_out_ovf;

endmodule

`default_nettype wire

// ===== dv/ssort_checker.sv =====
// Checker of the stack selection sorter: mirrors the stack, predicts each sorted run and compares.
module ssort_checker #(
    parameter int STACK_DEPTH = 64
) (
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_wrap_up,
    ssort_in_if   i_push_ch,
    ssort_out_if  i_sort_ch,
    output int    o_fail_count,
    output int    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import ssort_pkg::*;

    typedef struct packed {
        logic signed [VALUE_W-1:0] sorted_value;
        logic                      run_end;
        logic                      overflowed;
    } t_sorted;

    logic signed [VALUE_W-1:0] stack_mirror [STACK_DEPTH];
    int                        stack_fill;
    logic                      push_dropped;
    t_sorted                   ascending_q [$];
    int                        mismatches;
    bit                        wrap_seen;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        stack_fill   = 0;
        push_dropped = 1'b0;
        mismatches   = 0;
        wrap_seen    = 1'b0;
    end

    // Selection sort over a copy of the stack; every pass yields the next transfer.
    function automatic void sort_stack_into_queue();
        logic signed [VALUE_W-1:0] work [STACK_DEPTH];
        logic signed [VALUE_W-1:0] held;
        int                        lowest;
        t_sorted                   run_item;
        for (int k = 0; k < stack_fill; k++) work[k] = stack_mirror[k];
        for (int pass = 0; pass < stack_fill; pass++) begin
            lowest = pass;
            for (int k = pass + 1; k < stack_fill; k++) begin
                if (work[k] < work[lowest]) lowest = k;
            end
            held         = work[pass];
            work[pass]   = work[lowest];
            work[lowest] = held;
            run_item.sorted_value = work[pass];
            run_item.run_end      = (pass + 1 == stack_fill);
            run_item.overflowed   = push_dropped;
            ascending_q.push_back(run_item);
        end
    endfunction

    function automatic void check_field(string field, logic signed [VALUE_W-1:0] want,
                                        logic signed [VALUE_W-1:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_sorted want;
        if (!i_rst_n) begin
            stack_fill   = 0;
            push_dropped = 1'b0;
            ascending_q.delete();
        end else begin
            // Results of one batch never share a cycle with pushes of the same batch,
            // so the output side is handled first.
            if (i_sort_ch.valid === 1'b1 && i_sort_ch.ready === 1'b1) begin
                if (ascending_q.size() == 0) begin
                    $display("%0t ns: unexpected transfer, expected none, actual %0d/%0b/%0b",
                             $time, i_sort_ch.sorted_value, i_sort_ch.run_end,
                             i_sort_ch.overflowed);
                    mismatches++;
                end else begin
                    want = ascending_q.pop_front();
                    check_field("sorted_value", want.sorted_value, i_sort_ch.sorted_value);
                    check_field("run_end", want.run_end, i_sort_ch.run_end);
                    check_field("overflowed", want.overflowed, i_sort_ch.overflowed);
                end
            end
            if (i_push_ch.valid === 1'b1 && i_push_ch.ready === 1'b1) begin
                if (stack_fill < STACK_DEPTH) begin
                    stack_mirror[stack_fill] = i_push_ch.item_value;
                    stack_fill++;
                end else begin
                    push_dropped = 1'b1;
                end
                if (i_push_ch.batch_end === 1'b1) begin
                    sort_stack_into_queue();
                    stack_fill   = 0;
                    push_dropped = 1'b0;
                end
            end
            if (i_wrap_up && !wrap_seen) begin
                wrap_seen = 1'b1;
                if (ascending_q.size() != 0) begin
                    $display("%0t ns: %0d results never arrived, expected next %0d, actual none",
                             $time, ascending_q.size(), ascending_q[0].sorted_value);
                    mismatches += ascending_q.size();
                end
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= ascending_q.size();
    end

endmodule

// ===== dv/tb_top.sv =====
// Testbench top of the stack selection sorter: clock, reset, stimulus, receiver and verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ssort_pkg::*;

    localparam int STACK_DEPTH  = 64;
    localparam int ITEM_TARGET  = 410;
    localparam int IDLE_LIMIT   = 5000;
    localparam int LONG_HOLD    = 600;
    localparam int DRAIN_CYCLES = 3 * STACK_DEPTH;

    localparam logic signed [VALUE_W-1:0] VAL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
    localparam logic signed [VALUE_W-1:0] VAL_MAX = {1'b0, {(VALUE_W-1){1'b1}}};

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic wrap_up;
    int   fail_count;
    int   pending_results;
    int   items_sent    = 0;
    bit   sender_steady = 1'b0;
    int   idle_cycles   = 0;

    ssort_in_if  push_ch ();
    ssort_out_if sort_ch ();

    stack_selection_sort #(.STACK_DEPTH(STACK_DEPTH)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (push_ch),
        .o_out   (sort_ch)
    );

    ssort_checker #(.STACK_DEPTH(STACK_DEPTH)) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_wrap_up    (wrap_up),
        .i_push_ch    (push_ch),
        .i_sort_ch    (sort_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending_results)
    );

    always #6 i_clk = ~i_clk;

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [VALUE_W-1:0] pick_value(input int style);
        case (style)
            0: return $urandom;
            1: return $signed($urandom_range(0, 8)) - 4;
            2: begin
                case ($urandom_range(0, 5))
                    0: return VAL_MIN;
                    1: return VAL_MAX;
                    2: return 0;
                    3: return -1;
                    4: return VAL_MIN + 1;
                    default: return VAL_MAX - 1;
                endcase
            end
            default: return ($urandom_range(0, 1) != 0) ? $urandom : $signed($urandom_range(0, 3));
        endcase
    endfunction

    task automatic push_item(input logic signed [VALUE_W-1:0] value, input logic last);
        int gap;
        gap = sender_steady ? 0 : pick_gap();
        if (gap > 0) begin
            push_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push_ch.valid      <= 1'b1;
        push_ch.item_value <= value;
        push_ch.batch_end  <= last;
        do @(posedge i_clk); while (push_ch.ready !== 1'b1);
        items_sent++;
    endtask

    task automatic push_batch(input int size, input int style);
        for (int k = 0; k < size; k++) push_item(pick_value(style), k == size - 1);
    endtask

    initial begin
        logic signed [VALUE_W-1:0] extremes [9];
        int r;
        int size;
        extremes = '{VAL_MIN, VAL_MAX, 0, -1, 1, VAL_MAX, VAL_MIN, 32'sh5555_5555,
                     32'shAAAA_AAAA};
        push_ch.valid      <= 1'b0;
        push_ch.item_value <= '0;
        push_ch.batch_end  <= 1'b0;
        wrap_up            <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Extremes with duplicates, a single value, all equal, and a descending run.
        foreach (extremes[k]) push_item(extremes[k], k == 8);
        push_item(-7, 1'b1);
        repeat (3) push_item(42, 1'b0);
        push_item(42, 1'b1);
        push_item(100, 1'b0);
        push_item(50, 1'b0);
        push_item(-50, 1'b1);

        // A batch that exactly fills the stack, then one whose last two values, the end item's among them, are dropped.
        push_batch(STACK_DEPTH, 0);
        push_batch(STACK_DEPTH + 2, 3);

        while (items_sent < ITEM_TARGET) begin
            sender_steady = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            if (r < 65)      size = $urandom_range(1, 8);
            else if (r < 85) size = $urandom_range(9, 24);
            else if (r < 94) size = $urandom_range(STACK_DEPTH - 4, STACK_DEPTH);
            else             size = $urandom_range(STACK_DEPTH + 1, STACK_DEPTH + 8);
            push_batch(size, $urandom_range(0, 3));
        end
        push_ch.valid <= 1'b0;

        // The checker's pending count is a registered copy of its queue size, so it lags the last batch.
        @(posedge i_clk);
        while (pending_results != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        wrap_up <= 1'b1;
        repeat (2) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Receiver: random stalls, calm stretches, and one long hold-off once results flow.
    initial begin
        int  hold      = 0;
        int  mode_left = 0;
        bit  steady    = 1'b0;
        bit  long_done = 1'b0;
        sort_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (mode_left == 0) begin
                steady    = ($urandom_range(0, 3) == 0);
                mode_left = $urandom_range(100, 400);
            end
            mode_left--;
            if (!long_done && items_sent >= 120 && sort_ch.valid === 1'b1) begin
                hold      = LONG_HOLD;
                long_done = 1'b1;
            end
            if (hold > 0) begin
                sort_ch.ready <= 1'b0;
                hold--;
            end else if (!steady && $urandom_range(0, 99) < 30) begin
                sort_ch.ready <= 1'b0;
                hold = pick_gap();
            end else begin
                sort_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((push_ch.valid === 1'b1 && push_ch.ready === 1'b1) ||
                (sort_ch.valid === 1'b1 && sort_ch.ready === 1'b1)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t ns: no transfer for %0d cycles", $time, idle_cycles);
                $display("[FAIL] regression broken");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

endmodule

// ===== sim.f =====
rtl/core/ssort_pkg.sv
rtl/core/ssort_if.sv
rtl/core/ssort_ram.sv
rtl/core/ssort_min_unit.sv
rtl/core/stack_selection_sort.sv
dv/ssort_checker.sv
dv/tb_top.sv
